// File: rtl/core/sat_pkg.sv
// Shared opcodes, register indexes and token control type for the segment translator.
`timescale 1ns / 1ps
`default_nettype none

package sat_pkg;

   localparam int OPCODE_W   = 2;
   localparam int ENTRY_W    = 4;
   localparam int COUNT_W    = 5;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 32;

   localparam logic [OPCODE_W-1:0] OP_LOAD = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_V2F  = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_F2V  = 2'd2;
   localparam logic [OPCODE_W-1:0] OP_NONE = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_SEGMENTS_IN_USE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_RAW_SIZE        = 1'b1;

   typedef struct packed {
      logic                valid;
      logic [OPCODE_W-1:0] opcode;
      logic [ENTRY_W-1:0]  entry_index;
      logic                hit;
      logic [ENTRY_W-1:0]  hit_index;
   } token_ctrl_type;

endpackage

`default_nettype wire

// File: rtl/core/sat_cell.sv
// One table cell: holds one segment entry and hands the passing token to the next cell.
`timescale 1ns / 1ps
`default_nettype none

module sat_cell #(
   parameter int INDEX     = 0,
   parameter int ADDR_BITS = 32
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           advance,
   input  wire logic [sat_pkg::COUNT_W-1:0]    seg_count,
   input  wire sat_pkg::token_ctrl_type        in_ctrl,
   input  wire logic [ADDR_BITS-1:0]           in_q,
   input  wire logic [ADDR_BITS-1:0]           in_lo,
   input  wire logic [ADDR_BITS-1:0]           in_base,
   input  wire logic [ADDR_BITS-1:0]           in_vs,
   input  wire logic [ADDR_BITS-1:0]           in_ve,
   input  wire logic [ADDR_BITS-1:0]           in_fs,
   input  wire logic [ADDR_BITS-1:0]           in_fl,
   output sat_pkg::token_ctrl_type             out_ctrl,
   output logic [ADDR_BITS-1:0]                out_q,
   output logic [ADDR_BITS-1:0]                out_lo,
   output logic [ADDR_BITS-1:0]                out_base,
   output logic [ADDR_BITS-1:0]                out_vs,
   output logic [ADDR_BITS-1:0]                out_ve,
   output logic [ADDR_BITS-1:0]                out_fs,
   output logic [ADDR_BITS-1:0]                out_fl
);
   import sat_pkg::*;

   logic [ADDR_BITS-1:0] vs_ff, ve_ff, fs_ff, fl_ff;
   logic [ADDR_BITS:0]   fs_limit;
   logic                 active, load_here, v_match, f_match, take;

   token_ctrl_type       ctrl_ff, ctrl_in;
   logic [ADDR_BITS-1:0] q_ff, lo_ff, base_ff, lo_in, base_in;
   logic [ADDR_BITS-1:0] ld_vs_ff, ld_ve_ff, ld_fs_ff, ld_fl_ff;

   always_comb begin
      active    = INDEX < int'(seg_count);
      load_here = in_ctrl.valid && (in_ctrl.opcode == OP_LOAD)
                  && (int'(in_ctrl.entry_index) == INDEX);
      fs_limit  = {1'b0, fs_ff} + {1'b0, fl_ff};
      v_match   = (vs_ff <= in_q) && (ve_ff >= in_q);
      f_match   = (fs_ff <= in_q) && (fs_limit >= {1'b0, in_q});
      take      = in_ctrl.valid && active && !in_ctrl.hit
                  && (((in_ctrl.opcode == OP_V2F) && v_match)
                   || ((in_ctrl.opcode == OP_F2V) && f_match));
      ctrl_in   = in_ctrl;
      lo_in     = in_lo;
      base_in   = in_base;
      if (take) begin
         ctrl_in.hit       = 1'b1;
         ctrl_in.hit_index = ENTRY_W'(INDEX);
         if (in_ctrl.opcode == OP_V2F) begin
            lo_in   = vs_ff;
            base_in = fs_ff;
         end else begin
            lo_in   = fs_ff;
            base_in = vs_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else if (advance) begin
         ctrl_ff <= ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         q_ff     <= in_q;
         lo_ff    <= lo_in;
         base_ff  <= base_in;
         ld_vs_ff <= in_vs;
         ld_ve_ff <= in_ve;
         ld_fs_ff <= in_fs;
         ld_fl_ff <= in_fl;
         if (load_here) begin
            vs_ff <= in_vs;
            ve_ff <= in_ve;
            fs_ff <= in_fs;
            fl_ff <= in_fl;
         end
      end
   end

   assign out_ctrl = ctrl_ff;
   assign out_q    = q_ff;
   assign out_lo   = lo_ff;
   assign out_base = base_ff;
   assign out_vs   = ld_vs_ff;
   assign out_ve   = ld_ve_ff;
   assign out_fs   = ld_fs_ff;
   assign out_fl   = ld_fl_ff;

endmodule

`default_nettype wire

// File: rtl/core/sat_finish.sv
// Rebase and raw-mode stages after the cell chain, ending in the result register.
`timescale 1ns / 1ps
`default_nettype none

module sat_finish #(
   parameter int MAX_SEGMENTS = 16,
   parameter int ADDR_BITS    = 32
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             advance,
   input  wire logic                             raw_mode,
   input  wire logic [sat_pkg::CSR_DATA_W-1:0]   raw_size,
   input  wire sat_pkg::token_ctrl_type          in_ctrl,
   input  wire logic [ADDR_BITS-1:0]             in_q,
   input  wire logic [ADDR_BITS-1:0]             in_lo,
   input  wire logic [ADDR_BITS-1:0]             in_base,
   output logic                                  rsp_valid,
   output logic                                  rsp_found,
   output logic [ADDR_BITS-1:0]                  rsp_translated_address,
   output logic [sat_pkg::ENTRY_W-1:0]           rsp_hit_index,
   output logic [ADDR_BITS-1:0]                  rsp_offset_in_segment
);
   import sat_pkg::*;

   localparam int CMP_W = (ADDR_BITS > CSR_DATA_W) ? ADDR_BITS : CSR_DATA_W;

   token_ctrl_type       a_ctrl_ff;
   logic [ADDR_BITS-1:0] a_q_ff, a_base_ff, a_diff_ff;
   logic                 a_raw_ok_ff;

   logic [ADDR_BITS:0]   sum;
   logic                 valid_ff, found_ff, found_in;
   logic [ADDR_BITS-1:0] trans_ff, trans_in, offset_ff, offset_in;
   logic [ENTRY_W-1:0]   hit_ff, hit_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ctrl_ff <= '0;
      end else if (advance) begin
         a_ctrl_ff <= in_ctrl;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_q_ff      <= in_q;
         a_base_ff   <= in_base;
         a_diff_ff   <= in_q - in_lo;
         a_raw_ok_ff <= CMP_W'(in_q) < CMP_W'(raw_size);
      end
   end

   always_comb begin
      sum       = {1'b0, a_diff_ff} + {1'b0, a_base_ff};
      found_in  = 1'b0;
      trans_in  = '0;
      hit_in    = '0;
      offset_in = '0;
      case (a_ctrl_ff.opcode)
         OP_LOAD: begin
            found_in = int'(a_ctrl_ff.entry_index) < MAX_SEGMENTS;
         end
         OP_V2F, OP_F2V: begin
            if (raw_mode) begin
               if (a_raw_ok_ff) begin
                  found_in  = 1'b1;
                  trans_in  = a_q_ff;
                  offset_in = a_q_ff;
               end
            end else if (a_ctrl_ff.hit && !sum[ADDR_BITS]) begin
               found_in  = 1'b1;
               trans_in  = sum[ADDR_BITS-1:0];
               hit_in    = a_ctrl_ff.hit_index;
               offset_in = a_diff_ff;
            end
         end
         default: begin
            found_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= a_ctrl_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         found_ff  <= found_in;
         trans_ff  <= trans_in;
         hit_ff    <= hit_in;
         offset_ff <= offset_in;
      end
   end

   assign rsp_valid              = valid_ff;
   assign rsp_found              = found_ff;
   assign rsp_translated_address = trans_ff;
   assign rsp_hit_index          = hit_ff;
   assign rsp_offset_in_segment  = offset_ff;

   a_miss_is_zero: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !found_ff) |-> (trans_ff == '0 && hit_ff == '0 && offset_ff == '0))
      else $error("miss result carries non-zero fields");

   a_raw_passthrough: assert property (@(posedge clock) disable iff (reset)
      (advance && a_ctrl_ff.valid && raw_mode && found_in
       && (a_ctrl_ff.opcode == OP_V2F || a_ctrl_ff.opcode == OP_F2V))
      |=> (trans_ff == offset_ff && hit_ff == '0))
      else $error("raw-mode hit does not pass the address through");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (!advance && valid_ff) |=> ($stable(found_ff) && $stable(trans_ff) && valid_ff))
      else $error("result register changed while stalled");

   a_load_no_hit: assert property (@(posedge clock) disable iff (reset)
      (advance && a_ctrl_ff.valid && a_ctrl_ff.opcode == OP_LOAD)
      |=> (trans_ff == '0 && offset_ff == '0))
      else $error("load transfer produced address fields");

endmodule

`default_nettype wire

// File: rtl/core/segment_address_translator_top.sv
// Top level of the segment address translator: register port, cell chain and result stage.
//
//   channel  direction  transfer when          carries
//   req_     in         req_valid & req_ready  one load or one translation request
//   rsp_     out        rsp_valid & rsp_ready  one result for each request, in order
//   csr_     in         csr_we                 segments_in_use (0), raw_size (1)
//
// One request enters per cycle unless rsp_ready stalls the chain; each passes one register
// per table cell, then the rebase stage and the result register.
// Reset clears the token valid flags and both registers; the table itself is not cleared.
// A stall on rsp_ready freezes the whole chain and drops req_ready in the same cycle.
`timescale 1ns / 1ps
`default_nettype none

module segment_address_translator_top #(
   parameter int MAX_SEGMENTS = 16,
   parameter int ADDR_BITS    = 32
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [sat_pkg::OPCODE_W-1:0]     req_opcode,
   input  wire logic [sat_pkg::ENTRY_W-1:0]      req_entry_index,
   input  wire logic [ADDR_BITS-1:0]             req_query_address,
   input  wire logic [ADDR_BITS-1:0]             req_new_virt_start,
   input  wire logic [ADDR_BITS-1:0]             req_new_virt_end,
   input  wire logic [ADDR_BITS-1:0]             req_new_file_start,
   input  wire logic [ADDR_BITS-1:0]             req_new_file_length,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic                                  rsp_found,
   output logic [ADDR_BITS-1:0]                  rsp_translated_address,
   output logic [sat_pkg::ENTRY_W-1:0]           rsp_hit_index,
   output logic [ADDR_BITS-1:0]                  rsp_offset_in_segment,
   input  wire logic                             csr_we,
   input  wire logic [sat_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [sat_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import sat_pkg::*;

   logic [COUNT_W-1:0]    segments_in_use_ff;
   logic [CSR_DATA_W-1:0] raw_size_ff;
   logic [COUNT_W-1:0]    seg_count;
   logic                  advance;

   token_ctrl_type        chain_ctrl [MAX_SEGMENTS+1];
   logic [ADDR_BITS-1:0]  chain_q    [MAX_SEGMENTS+1];
   logic [ADDR_BITS-1:0]  chain_lo   [MAX_SEGMENTS+1];
   logic [ADDR_BITS-1:0]  chain_base [MAX_SEGMENTS+1];
   logic [ADDR_BITS-1:0]  chain_vs   [MAX_SEGMENTS+1];
   logic [ADDR_BITS-1:0]  chain_ve   [MAX_SEGMENTS+1];
   logic [ADDR_BITS-1:0]  chain_fs   [MAX_SEGMENTS+1];
   logic [ADDR_BITS-1:0]  chain_fl   [MAX_SEGMENTS+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         segments_in_use_ff <= '0;
         raw_size_ff        <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SEGMENTS_IN_USE: segments_in_use_ff <= csr_wdata[COUNT_W-1:0];
            CSR_RAW_SIZE:        raw_size_ff        <= csr_wdata;
            default:             raw_size_ff        <= raw_size_ff;
         endcase
      end
   end

   assign seg_count = (int'(segments_in_use_ff) > MAX_SEGMENTS)
                      ? COUNT_W'(MAX_SEGMENTS) : segments_in_use_ff;
   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   assign chain_ctrl[0] = '{valid: req_valid, opcode: req_opcode,
                            entry_index: req_entry_index, hit: 1'b0, hit_index: '0};

   assign chain_q[0]    = req_query_address;
   assign chain_lo[0]   = '0;
   assign chain_base[0] = '0;
   assign chain_vs[0]   = req_new_virt_start;
   assign chain_ve[0]   = req_new_virt_end;
   assign chain_fs[0]   = req_new_file_start;
   assign chain_fl[0]   = req_new_file_length;

   for (genvar i = 0; i < MAX_SEGMENTS; i++) begin : g_cell
      sat_cell #(
         .INDEX     (i),
         .ADDR_BITS (ADDR_BITS)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .seg_count (seg_count),
         .in_ctrl   (chain_ctrl[i]),
         .in_q      (chain_q[i]),
         .in_lo     (chain_lo[i]),
         .in_base   (chain_base[i]),
         .in_vs     (chain_vs[i]),
         .in_ve     (chain_ve[i]),
         .in_fs     (chain_fs[i]),
         .in_fl     (chain_fl[i]),
         .out_ctrl  (chain_ctrl[i+1]),
         .out_q     (chain_q[i+1]),
         .out_lo    (chain_lo[i+1]),
         .out_base  (chain_base[i+1]),
         .out_vs    (chain_vs[i+1]),
         .out_ve    (chain_ve[i+1]),
         .out_fs    (chain_fs[i+1]),
         .out_fl    (chain_fl[i+1])
      );
   end

   sat_finish #(
      .MAX_SEGMENTS (MAX_SEGMENTS),
      .ADDR_BITS    (ADDR_BITS)
   ) u_finish (
      .clock                  (clock),
      .reset                  (reset),
      .advance                (advance),
      .raw_mode               (seg_count == '0),
      .raw_size               (raw_size_ff),
      .in_ctrl                (chain_ctrl[MAX_SEGMENTS]),
      .in_q                   (chain_q[MAX_SEGMENTS]),
      .in_lo                  (chain_lo[MAX_SEGMENTS]),
      .in_base                (chain_base[MAX_SEGMENTS]),
      .rsp_valid              (rsp_valid),
      .rsp_found              (rsp_found),
      .rsp_translated_address (rsp_translated_address),
      .rsp_hit_index          (rsp_hit_index),
      .rsp_offset_in_segment  (rsp_offset_in_segment)
   );

endmodule

`default_nettype wire

// File: bench/testbench.sv
// Self-checking bench for the segment address translator: directed corners, then random traffic.
`timescale 1ns / 1ps

module testbench;
   import sat_pkg::*;

   localparam int MAX_SEGMENTS   = 16;
   localparam int ADDR_BITS      = 32;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_PHASES  = 11;
   localparam int PHASE_ITEMS    = 58;
   localparam int REPORT_LIMIT   = 100;

   typedef struct packed {
      logic [OPCODE_W-1:0]  opcode;
      logic [ENTRY_W-1:0]   entry_index;
      logic [ADDR_BITS-1:0] query_address;
      logic [ADDR_BITS-1:0] new_virt_start;
      logic [ADDR_BITS-1:0] new_virt_end;
      logic [ADDR_BITS-1:0] new_file_start;
      logic [ADDR_BITS-1:0] new_file_length;
   } request_type;

   typedef struct packed {
      logic                 found;
      logic [ADDR_BITS-1:0] translated_address;
      logic [ENTRY_W-1:0]   hit_index;
      logic [ADDR_BITS-1:0] offset_in_segment;
   } response_type;

   class translation_scoreboard;
      bit [ADDR_BITS-1:0] virt_start [MAX_SEGMENTS];
      bit [ADDR_BITS-1:0] virt_end [MAX_SEGMENTS];
      bit [ADDR_BITS-1:0] file_base [MAX_SEGMENTS];
      bit [ADDR_BITS-1:0] file_length [MAX_SEGMENTS];
      bit [COUNT_W-1:0]   segments_in_use;
      bit [ADDR_BITS-1:0] raw_size;
      response_type       pending_results [$];
      int unsigned        mismatches;

      function new();
         segments_in_use = '0;
         raw_size = '0;
         mismatches = 0;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] index, bit [CSR_DATA_W-1:0] value);
         if (index == CSR_SEGMENTS_IN_USE) begin
            segments_in_use = value[COUNT_W-1:0];
         end else begin
            raw_size = value[ADDR_BITS-1:0];
         end
      endfunction

      function int unsigned active_entries();
         return (segments_in_use > MAX_SEGMENTS) ? MAX_SEGMENTS : segments_in_use;
      endfunction

      // Apply one request to the table and work out its result.
      function response_type translate(request_type r);
         response_type       res;
         bit [ADDR_BITS:0]   span_end;
         bit [ADDR_BITS:0]   rebased;
         bit [ADDR_BITS-1:0] lo;
         bit [ADDR_BITS-1:0] base;
         bit [ADDR_BITS-1:0] delta;
         bit [ADDR_BITS-1:0] q;
         bit                 hit;
         bit                 done;
         int unsigned        n;
         int unsigned        i;
         res = '0;
         q = r.query_address;
         n = active_entries();
         done = 1'b0;
         case (r.opcode)
            OP_LOAD: begin
               if (r.entry_index < MAX_SEGMENTS) begin
                  virt_start[r.entry_index] = r.new_virt_start;
                  virt_end[r.entry_index] = r.new_virt_end;
                  file_base[r.entry_index] = r.new_file_start;
                  file_length[r.entry_index] = r.new_file_length;
                  res.found = 1'b1;
               end
            end
            OP_V2F, OP_F2V: begin
               if (n == 0) begin
                  if (q < raw_size) begin
                     res.found = 1'b1;
                     res.translated_address = q;
                     res.offset_in_segment = q;
                  end
               end else begin
                  for (i = 0; i < n && !done; i++) begin
                     if (r.opcode == OP_V2F) begin
                        lo = virt_start[i];
                        base = file_base[i];
                        hit = (lo <= q) && (virt_end[i] >= q);
                     end else begin
                        lo = file_base[i];
                        base = virt_start[i];
                        span_end = {1'b0, lo} + {1'b0, file_length[i]};
                        hit = (lo <= q) && (span_end >= {1'b0, q});
                     end
                     if (hit) begin
                        done = 1'b1;
                        delta = q - lo;
                        rebased = {1'b0, delta} + {1'b0, base};
                        if (!rebased[ADDR_BITS]) begin
                           res.found = 1'b1;
                           res.translated_address = rebased[ADDR_BITS-1:0];
                           res.hit_index = ENTRY_W'(i);
                           res.offset_in_segment = delta;
                        end
                     end
                  end
               end
            end
            default: res = '0;
         endcase
         return res;
      endfunction

      function void note_request(request_type r);
         pending_results.push_back(translate(r));
      endfunction

      task report_mismatch(string line);
         if (mismatches < REPORT_LIMIT) begin
            $display("[%0t] mismatch: %s", $realtime, line);
         end
         mismatches++;
      endtask

      task check_field(string name, logic [ADDR_BITS-1:0] got, logic [ADDR_BITS-1:0] want);
         if (got !== want) begin
            report_mismatch($sformatf("%s got %h expected %h", name, got, want));
         end
      endtask

      task check_response(response_type got);
         response_type want;
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("result transfer with nothing outstanding: %h", got));
         end else begin
            want = pending_results.pop_front();
            check_field("found", got.found, want.found);
            check_field("translated_address", got.translated_address, want.translated_address);
            check_field("hit_index", got.hit_index, want.hit_index);
            check_field("offset_in_segment", got.offset_in_segment, want.offset_in_segment);
         end
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [OPCODE_W-1:0]   req_opcode = OP_NONE;
   logic [ENTRY_W-1:0]    req_entry_index = '0;
   logic [ADDR_BITS-1:0]  req_query_address = '0;
   logic [ADDR_BITS-1:0]  req_new_virt_start = '0;
   logic [ADDR_BITS-1:0]  req_new_virt_end = '0;
   logic [ADDR_BITS-1:0]  req_new_file_start = '0;
   logic [ADDR_BITS-1:0]  req_new_file_length = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_found;
   logic [ADDR_BITS-1:0]  rsp_translated_address;
   logic [ENTRY_W-1:0]    rsp_hit_index;
   logic [ADDR_BITS-1:0]  rsp_offset_in_segment;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_SEGMENTS_IN_USE;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   translation_scoreboard sb = new();
   response_type          seen;
   bit                    idling = 1'b1;
   int unsigned           stall_left = 0;
   int unsigned           quiet_cycles = 0;

   segment_address_translator_top #(
      .MAX_SEGMENTS(MAX_SEGMENTS),
      .ADDR_BITS(ADDR_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_opcode(req_opcode),
      .req_entry_index(req_entry_index),
      .req_query_address(req_query_address),
      .req_new_virt_start(req_new_virt_start),
      .req_new_virt_end(req_new_virt_end),
      .req_new_file_start(req_new_file_start),
      .req_new_file_length(req_new_file_length),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_found(rsp_found),
      .rsp_translated_address(rsp_translated_address),
      .rsp_hit_index(rsp_hit_index),
      .rsp_offset_in_segment(rsp_offset_in_segment),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 0;
   end

   function automatic int unsigned idle_cycles(int unsigned zero_pct);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < zero_pct) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         seen.found = rsp_found;
         seen.translated_address = rsp_translated_address;
         seen.hit_index = rsp_hit_index;
         seen.offset_in_segment = rsp_offset_in_segment;
         sb.check_response(seen);
      end
      if (stall_left != 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (idling && $urandom_range(0, 3) == 0) begin
         stall_left = idle_cycles(0) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic request_type noise_request();
      request_type r;
      r.opcode = OPCODE_W'($urandom_range(0, 3));
      r.entry_index = ENTRY_W'($urandom_range(0, MAX_SEGMENTS - 1));
      r.query_address = $urandom;
      r.new_virt_start = $urandom;
      r.new_virt_end = $urandom;
      r.new_file_start = $urandom;
      r.new_file_length = $urandom;
      return r;
   endfunction

   // Shape a segment: crowded low window, wide random, top of space, rebase overflow, inverted.
   function automatic request_type load_request(int unsigned index);
      request_type        r;
      bit [ADDR_BITS-1:0] low_addr;
      bit [ADDR_BITS-1:0] high_addr;
      r = noise_request();
      r.opcode = OP_LOAD;
      r.entry_index = ENTRY_W'(index);
      low_addr = $urandom_range(0, 'hFFFF);
      high_addr = 32'hFFFF_FFFF - $urandom_range(0, 'hFFF);
      case ($urandom_range(0, 4))
         0: begin
            r.new_virt_start = low_addr;
            r.new_virt_end = low_addr + $urandom_range(0, 'hFFF);
            r.new_file_start = $urandom_range(0, 'hFFFF);
            r.new_file_length = $urandom_range(0, 'hFFF);
         end
         1: ;
         2: begin
            r.new_virt_start = 32'hFFFF_FFFF - $urandom_range(0, 'hFFFF);
            r.new_virt_end = 32'hFFFF_FFFF;
            r.new_file_start = 32'hFFFF_FFFF - $urandom_range(0, 'hFFFF);
         end
         3: begin
            if ($urandom_range(0, 1) == 0) begin
               r.new_virt_start = low_addr;
               r.new_virt_end = low_addr + $urandom_range(0, 'hFFFF);
               r.new_file_start = high_addr;
            end else begin
               r.new_virt_start = high_addr;
               r.new_virt_end = 32'hFFFF_FFFF;
               r.new_file_start = low_addr;
            end
            r.new_file_length = $urandom_range(0, 'hFFFF);
         end
         default: begin
            r.new_virt_end = r.new_virt_start - 1 - $urandom_range(0, 'hFFF);
         end
      endcase
      return r;
   endfunction

   // Aim a query at the bounds of a live segment, or at the raw bound.
   function automatic request_type targeted_query();
      request_type        r;
      bit [ADDR_BITS-1:0] lo;
      bit [ADDR_BITS-1:0] hi;
      int unsigned        n;
      int unsigned        i;
      r = noise_request();
      r.opcode = ($urandom_range(0, 1) == 0) ? OP_V2F : OP_F2V;
      n = sb.active_entries();
      if (n == 0) begin
         lo = '0;
         hi = sb.raw_size;
      end else begin
         i = $urandom_range(0, n - 1);
         if (r.opcode == OP_V2F) begin
            lo = sb.virt_start[i];
            hi = sb.virt_end[i];
         end else begin
            lo = sb.file_base[i];
            hi = sb.file_base[i] + sb.file_length[i];
         end
      end
      case ($urandom_range(0, 5))
         0: r.query_address = lo - 1;
         1: r.query_address = lo;
         2: r.query_address = hi;
         3: r.query_address = hi + 1;
         4: r.query_address = (hi >= lo) ? lo + $urandom_range(0, hi - lo) : lo;
         default: ;
      endcase
      return r;
   endfunction

   task automatic send_request(input request_type r);
      int unsigned gap;
      gap = idling ? idle_cycles(60) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= r.opcode;
      req_entry_index <= r.entry_index;
      req_query_address <= r.query_address;
      req_new_virt_start <= r.new_virt_start;
      req_new_virt_end <= r.new_virt_end;
      req_new_file_start <= r.new_file_start;
      req_new_file_length <= r.new_file_length;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(r);
   endtask

   task automatic send_query(logic [OPCODE_W-1:0] opcode, logic [ADDR_BITS-1:0] address);
      request_type r;
      r = noise_request();
      r.opcode = opcode;
      r.query_address = address;
      send_request(r);
   endtask

   task automatic send_load(int unsigned index, logic [ADDR_BITS-1:0] vs,
                            logic [ADDR_BITS-1:0] ve, logic [ADDR_BITS-1:0] fs,
                            logic [ADDR_BITS-1:0] fl);
      request_type r;
      r = load_request(index);
      r.new_virt_start = vs;
      r.new_virt_end = ve;
      r.new_file_start = fs;
      r.new_file_length = fl;
      send_request(r);
   endtask

   // Drop valid and hold until every outstanding result has come back.
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending_results.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic configure(int unsigned segments, logic [ADDR_BITS-1:0] raw_bound);
      drain();
      csr_we <= 1'b1;
      csr_index <= CSR_SEGMENTS_IN_USE;
      csr_wdata <= CSR_DATA_W'(segments);
      @(posedge clock);
      sb.set_register(CSR_SEGMENTS_IN_USE, CSR_DATA_W'(segments));
      csr_index <= CSR_RAW_SIZE;
      csr_wdata <= raw_bound;
      @(posedge clock);
      sb.set_register(CSR_RAW_SIZE, raw_bound);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      int unsigned p;
      int unsigned k;
      int unsigned sel;
      int unsigned segment_plan [RANDOM_PHASES];
      logic [ADDR_BITS-1:0] raw_bound;
      segment_plan = '{0, 16, 1, 31, 0, 3, 17, 8, 0, 16, 2};

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      configure(0, 32'h0);
      send_query(OP_V2F, 32'h0);
      send_query(OP_F2V, 32'hFFFF_FFFF);
      configure(0, 32'h1000);
      send_query(OP_V2F, 32'h0FFF);
      send_query(OP_F2V, 32'h1000);
      configure(0, 32'hFFFF_FFFF);
      send_query(OP_F2V, 32'hFFFF_FFFE);
      send_query(OP_V2F, 32'hFFFF_FFFF);

      send_load(0, 32'h1000, 32'h1FFF, 32'h200, 32'h1000);
      send_load(1, 32'h0, 32'h0, 32'h0, 32'h0);
      send_load(2, 32'hFFFF_F000, 32'hFFFF_FFFF, 32'hFFFF_FF00, 32'hFFFF_FFFF);
      send_load(3, 32'h8000_0000, 32'h7000_0000, 32'h10, 32'h20);
      send_load(4, 32'h1800, 32'h2800, 32'h9000, 32'h80);
      send_load(5, 32'h10, 32'h20, 32'hFFFF_FFF0, 32'h100);

      configure(6, 32'h1000);
      send_query(OP_V2F, 32'h1000);
      send_query(OP_V2F, 32'h1FFF);
      send_query(OP_V2F, 32'h2000);
      send_query(OP_V2F, 32'h0);
      send_query(OP_V2F, 32'hFFFF_FFFF);
      send_query(OP_V2F, 32'h1F);
      send_query(OP_V2F, 32'h20);
      send_query(OP_V2F, 32'h8000_0000);
      send_query(OP_F2V, 32'h200);
      send_query(OP_F2V, 32'h1200);
      send_query(OP_F2V, 32'hFFFF_FFFF);
      send_query(OP_F2V, 32'h30);
      send_query(OP_NONE, 32'h1000);

      for (k = 6; k < MAX_SEGMENTS; k++) send_request(load_request(k));

      for (p = 0; p < RANDOM_PHASES; p++) begin
         case (p % 3)
            0: raw_bound = $urandom;
            1: raw_bound = 32'hFFFF_FFFF;
            default: raw_bound = $urandom_range(0, 'hFFFF);
         endcase
         configure(segment_plan[p], raw_bound);
         idling = (p % 3 != 2);
         for (k = 0; k < PHASE_ITEMS; k++) begin
            sel = $urandom_range(0, 99);
            if (sel < 20) send_request(load_request($urandom_range(0, MAX_SEGMENTS - 1)));
            else if (sel < 30) send_request(noise_request());
            else send_request(targeted_query());
         end
      end

      idling = 1'b1;
      drain();
      repeat (MAX_SEGMENTS + 4) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
